[rtl/core/tim_image_stream_decoder_core_defines.svh]
// ----------------------------------------------------------------------------
// tim image stream decoder assertion macros
// shared concurrent check forms, removable with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef TIM_IMAGE_STREAM_DECODER_CORE_DEFINES_SVH
`define TIM_IMAGE_STREAM_DECODER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TISD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define TISD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TISD_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define TISD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/core/tisd_pkg.sv]
// ----------------------------------------------------------------------------
// tim image stream decoder package
// shared types, codes and tables of the decoder
// ----------------------------------------------------------------------------
package tisd_pkg;

    localparam int DEF_MAX_CLUT_BLOCK_BYTES = 65536;
    localparam int DEF_CMD_DEPTH = 4;

    localparam logic [1:0] OP_SINGLE = 2'd0;
    localparam logic [1:0] OP_PAIR   = 2'd1;
    localparam logic [1:0] OP_GREY   = 2'd2;

    localparam logic [1:0] KIND_PALETTE = 2'd0;
    localparam logic [1:0] KIND_INDEXED = 2'd1;
    localparam logic [1:0] KIND_COLOUR  = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    localparam logic [2:0] ERR_MAGIC   = 3'd0;
    localparam logic [2:0] ERR_TYPE    = 3'd1;
    localparam logic [2:0] ERR_HEADER  = 3'd2;
    localparam logic [2:0] ERR_PALETTE = 3'd3;
    localparam logic [2:0] ERR_SIZE    = 3'd4;

    localparam logic [3:0] TYPE_4BIT      = 4'd0;
    localparam logic [3:0] TYPE_16BIT     = 4'd2;
    localparam logic [3:0] TYPE_24BIT     = 4'd3;
    localparam logic [3:0] TYPE_4BIT_CLUT = 4'd8;
    localparam logic [3:0] TYPE_8BIT_CLUT = 4'd9;

    localparam logic [7:0] MAGIC_FIRST = 8'h10;

    // 5-bit channel scaled to 8 bits, floor(c * 255 / 31)
    localparam logic [7:0] SCALE5 [32] = '{
        8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
        8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
        8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
        8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
    };

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  kind;
        logic [15:0] idx;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [16:0] col;
        logic [15:0] row;
        logic        eoi0;
        logic        eoi1;
        logic [2:0]  err;
    } cmd_t;

endpackage

[rtl/core/tisd_front.sv]
// ----------------------------------------------------------------------------
// tisd front
// parses header, palette and pixel bytes into output commands
// ----------------------------------------------------------------------------
module tisd_front
    import tisd_pkg::*;
#(
    parameter int MAX_CLUT_BLOCK_BYTES = DEF_MAX_CLUT_BLOCK_BYTES
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       start_of_file,
    output logic       cmd_push,
    output cmd_t       cmd
);

    localparam int POS_RAW = $clog2(MAX_CLUT_BLOCK_BYTES + 24);
    localparam int POS_W = (POS_RAW > 18) ? POS_RAW : 18;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_PIXELS = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    logic [1:0]       phase_reg, phase_next, phase_cur;
    logic [POS_W-1:0] pos_reg, pos_next, pos_cur;
    logic [3:0]       type_reg, type_next;
    logic [31:0]      clut_reg, clut_next, clut_full;
    logic [POS_W-1:0] pal_end_reg, pal_end_next;
    logic [POS_W-1:0] end_m4_reg, end_m4_next;
    logic [15:0]      asm_reg, asm_next;
    logic [15:0]      stride_reg, stride_next;
    logic [15:0]      height_reg, height_next;
    logic [17:0]      row_pix_reg, row_pix_next;
    logic [18:0]      used3_reg, used3_next;
    logic [16:0]      k_reg, k_next;
    logic [15:0]      row_reg, row_next;
    logic [16:0]      col3_reg, col3_next;
    logic [1:0]       m3_reg, m3_next;

    logic             tabled;
    logic [15:0]      word;
    logic [16:0]      s2;
    logic [33:0]      div3_prod;
    logic [17:0]      last_col;
    logic             last_row;
    logic [17:0]      c4;
    logic [17:0]      k1;
    logic [15:0]      colors;

    always_comb
    begin
        phase_cur = start_of_file ? PH_HEADER : phase_reg;
        pos_cur = start_of_file ? '0 : pos_reg;
        tabled = (type_reg == TYPE_4BIT_CLUT) || (type_reg == TYPE_8BIT_CLUT);
        word = {data_byte, asm_reg[7:0]};
        s2 = {word, 1'b0};
        div3_prod = 34'(s2) * 34'd43691;
        last_col = row_pix_reg - 18'd1;
        last_row = (({1'b0, row_reg} + 17'd1) == {1'b0, height_reg});
        c4 = {k_reg, 1'b0};
        k1 = {1'b0, k_reg} + 18'd1;
        clut_full = {data_byte, clut_reg[23:0]};
        colors = word;

        phase_next = phase_reg;
        pos_next = pos_reg;
        type_next = type_reg;
        clut_next = clut_reg;
        pal_end_next = pal_end_reg;
        end_m4_next = end_m4_reg;
        asm_next = asm_reg;
        stride_next = stride_reg;
        height_next = height_reg;
        row_pix_next = row_pix_reg;
        used3_next = used3_reg;
        k_next = k_reg;
        row_next = row_reg;
        col3_next = col3_reg;
        m3_next = m3_reg;
        cmd_push = 1'b0;
        cmd = '0;
        cmd.op = OP_SINGLE;

        if (accept)
        begin
            phase_next = phase_cur;
            pos_next = pos_cur;
            unique case (phase_cur)
                PH_HEADER:
                begin
                    pos_next = pos_cur + POS_W'(1);
                    if (pos_cur < POS_W'(4))
                    begin
                        if (data_byte != ((pos_cur == '0) ? MAGIC_FIRST : 8'd0))
                        begin
                            phase_next = PH_DONE;
                            cmd_push = 1'b1;
                            cmd.kind = KIND_ERROR;
                            cmd.err = ERR_MAGIC;
                        end
                    end
                    else if (pos_cur == POS_W'(4))
                    begin
                        type_next = data_byte[3:0];
                        end_m4_next = POS_W'(16);
                        if (!(data_byte[3:0] == TYPE_4BIT || data_byte[3:0] == TYPE_16BIT ||
                              data_byte[3:0] == TYPE_24BIT ||
                              data_byte[3:0] == TYPE_4BIT_CLUT ||
                              data_byte[3:0] == TYPE_8BIT_CLUT))
                        begin
                            phase_next = PH_DONE;
                            cmd_push = 1'b1;
                            cmd.kind = KIND_ERROR;
                            cmd.err = ERR_TYPE;
                        end
                    end
                    else if (pos_cur >= POS_W'(8) && pos_cur <= POS_W'(11))
                    begin
                        if (tabled)
                        begin
                            case (pos_cur[1:0])
                                2'd0: clut_next[7:0] = data_byte;
                                2'd1: clut_next[15:8] = data_byte;
                                2'd2: clut_next[23:16] = data_byte;
                                default:
                                begin
                                    clut_next[31:24] = data_byte;
                                    end_m4_next = POS_W'(clut_full) + POS_W'(16);
                                    if (clut_full > 32'(MAX_CLUT_BLOCK_BYTES))
                                    begin
                                        phase_next = PH_DONE;
                                        cmd_push = 1'b1;
                                        cmd.kind = KIND_ERROR;
                                        cmd.err = ERR_HEADER;
                                    end
                                end
                            endcase
                        end
                    end
                    else if (tabled && pos_cur == POS_W'(16))
                    begin
                        asm_next = {8'd0, data_byte};
                    end
                    else if (tabled && pos_cur == POS_W'(17))
                    begin
                        pal_end_next = POS_W'({colors, 1'b0}) + POS_W'(20);
                        if (colors == 16'd0 ||
                            ({15'd0, colors, 1'b0} + 32'd12) > clut_reg)
                        begin
                            phase_next = PH_DONE;
                            cmd_push = 1'b1;
                            cmd.kind = KIND_ERROR;
                            cmd.err = ERR_PALETTE;
                        end
                    end
                    else if (tabled && pos_cur >= POS_W'(20) && pos_cur < pal_end_reg)
                    begin
                        if (!pos_cur[0])
                        begin
                            asm_next = {8'd0, data_byte};
                        end
                        else
                        begin
                            cmd_push = 1'b1;
                            cmd.kind = KIND_PALETTE;
                            cmd.idx = 16'((pos_cur - POS_W'(20)) >> 1);
                            cmd.red = SCALE5[word[4:0]];
                            cmd.green = SCALE5[word[9:5]];
                            cmd.blue = SCALE5[word[14:10]];
                        end
                    end
                    else if (pos_cur == end_m4_reg || pos_cur == end_m4_reg + POS_W'(2))
                    begin
                        asm_next = {8'd0, data_byte};
                    end
                    else if (pos_cur == end_m4_reg + POS_W'(1))
                    begin
                        stride_next = word;
                        unique case (type_reg) inside
                            TYPE_4BIT, TYPE_4BIT_CLUT: row_pix_next = {word, 2'b00};
                            TYPE_8BIT_CLUT:            row_pix_next = {1'b0, s2};
                            TYPE_24BIT:                row_pix_next = {2'b00, div3_prod[32:17]};
                            default:                   row_pix_next = {2'b00, word};
                        endcase
                    end
                    else if (pos_cur == end_m4_reg + POS_W'(3))
                    begin
                        height_next = word;
                        used3_next = {1'b0, row_pix_reg} + {row_pix_reg, 1'b0};
                        if (row_pix_reg == 18'd0 || word == 16'd0)
                        begin
                            phase_next = PH_DONE;
                            cmd_push = 1'b1;
                            cmd.kind = KIND_ERROR;
                            cmd.err = ERR_SIZE;
                        end
                        else
                        begin
                            phase_next = PH_PIXELS;
                            row_next = '0;
                            k_next = '0;
                            col3_next = '0;
                            m3_next = '0;
                            if (type_reg == TYPE_4BIT)
                            begin
                                cmd_push = 1'b1;
                                cmd.op = OP_GREY;
                                cmd.kind = KIND_PALETTE;
                            end
                        end
                    end
                end
                PH_PIXELS:
                begin
                    cmd.row = row_reg;
                    unique case (type_reg) inside
                        TYPE_4BIT, TYPE_4BIT_CLUT:
                        begin
                            cmd_push = 1'b1;
                            cmd.op = OP_PAIR;
                            cmd.kind = KIND_INDEXED;
                            cmd.idx = {8'd0, data_byte};
                            cmd.col = c4[16:0];
                            cmd.eoi0 = last_row && (c4 == last_col);
                            cmd.eoi1 = last_row && ((c4 + 18'd1) == last_col);
                        end
                        TYPE_8BIT_CLUT:
                        begin
                            cmd_push = 1'b1;
                            cmd.kind = KIND_INDEXED;
                            cmd.idx = {8'd0, data_byte};
                            cmd.col = k_reg;
                            cmd.eoi0 = last_row && ({1'b0, k_reg} == last_col);
                        end
                        TYPE_16BIT:
                        begin
                            if (!k_reg[0])
                            begin
                                asm_next = {8'd0, data_byte};
                            end
                            else
                            begin
                                cmd_push = 1'b1;
                                cmd.kind = KIND_COLOUR;
                                cmd.red = {3'd0, word[4:0]};
                                cmd.green = {3'd0, word[9:5]};
                                cmd.blue = {3'd0, word[14:10]};
                                cmd.col = {1'b0, k_reg[16:1]};
                                cmd.eoi0 = last_row && ({2'b00, k_reg[16:1]} == last_col);
                            end
                        end
                        default:
                        begin
                            if ({2'b00, k_reg} < used3_reg)
                            begin
                                case (m3_reg)
                                    2'd0:
                                    begin
                                        asm_next[7:0] = data_byte;
                                        m3_next = 2'd1;
                                    end
                                    2'd1:
                                    begin
                                        asm_next[15:8] = data_byte;
                                        m3_next = 2'd2;
                                    end
                                    default:
                                    begin
                                        m3_next = 2'd0;
                                        col3_next = col3_reg + 17'd1;
                                        cmd_push = 1'b1;
                                        cmd.kind = KIND_COLOUR;
                                        cmd.red = asm_reg[7:0];
                                        cmd.green = asm_reg[15:8];
                                        cmd.blue = data_byte;
                                        cmd.col = col3_reg;
                                        cmd.eoi0 = last_row && ({1'b0, col3_reg} == last_col);
                                    end
                                endcase
                            end
                        end
                    endcase
                    if (k1 == {1'b0, stride_reg, 1'b0})
                    begin
                        k_next = '0;
                        m3_next = '0;
                        col3_next = '0;
                        row_next = row_reg + 16'd1;
                        if (last_row)
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    else
                    begin
                        k_next = k1[16:0];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            pos_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg <= type_next;
        clut_reg <= clut_next;
        pal_end_reg <= pal_end_next;
        end_m4_reg <= end_m4_next;
        asm_reg <= asm_next;
        stride_reg <= stride_next;
        height_reg <= height_next;
        row_pix_reg <= row_pix_next;
        used3_reg <= used3_next;
        k_reg <= k_next;
        row_reg <= row_next;
        col3_reg <= col3_next;
        m3_reg <= m3_next;
    end

endmodule

[rtl/core/tisd_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// tisd command queue
// short queue between the parsing front and the output back
// ----------------------------------------------------------------------------
module tisd_cmd_fifo
    import tisd_pkg::*;
#(
    parameter int DEPTH = DEF_CMD_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    output logic full,
    input  logic rd_en,
    output cmd_t rd_data,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

[rtl/core/tisd_back.sv]
// ----------------------------------------------------------------------------
// tisd back
// expands commands into result words held in the output register
// ----------------------------------------------------------------------------
module tisd_back
    import tisd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        head,
    input  logic        q_empty,
    output logic        q_pop,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  kind,
    output logic [15:0] index_value,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [16:0] column,
    output logic [15:0] row,
    output logic        end_of_image,
    output logic [2:0]  error_code
);

    logic        valid_reg, valid_next;
    logic [3:0]  sub_reg, sub_next;
    logic        adv, last;
    logic [1:0]  kind_reg;
    logic [15:0] idx_reg, idx_next;
    logic [7:0]  red_reg, red_next, green_reg, green_next, blue_reg, blue_next;
    logic [16:0] col_reg, col_next;
    logic [15:0] row_reg;
    logic        eoi_reg, eoi_next;
    logic [2:0]  err_reg;

    always_comb
    begin
        adv = !valid_reg || pop;
        unique case (head.op)
            OP_PAIR: last = (sub_reg == 4'd1);
            OP_GREY: last = (sub_reg == 4'd15);
            default: last = 1'b1;
        endcase
        q_pop = adv && !q_empty && last;
        valid_next = adv ? !q_empty : valid_reg;
        sub_next = sub_reg;
        if (adv && !q_empty)
        begin
            sub_next = last ? 4'd0 : sub_reg + 4'd1;
        end

        idx_next = head.idx;
        red_next = head.red;
        green_next = head.green;
        blue_next = head.blue;
        col_next = head.col;
        eoi_next = head.eoi0;
        unique case (head.op)
            OP_PAIR:
            begin
                if (sub_reg[0])
                begin
                    idx_next = {12'd0, head.idx[7:4]};
                    col_next = head.col + 17'd1;
                    eoi_next = head.eoi1;
                end
                else
                begin
                    idx_next = {12'd0, head.idx[3:0]};
                end
            end
            OP_GREY:
            begin
                idx_next = {12'd0, sub_reg};
                red_next = {sub_reg, sub_reg};
                green_next = {sub_reg, sub_reg};
                blue_next = {sub_reg, sub_reg};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sub_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            sub_reg <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && !q_empty)
        begin
            kind_reg <= head.kind;
            idx_reg <= idx_next;
            red_reg <= red_next;
            green_reg <= green_next;
            blue_reg <= blue_next;
            col_reg <= col_next;
            row_reg <= head.row;
            eoi_reg <= eoi_next;
            err_reg <= head.err;
        end
    end

    assign empty = !valid_reg;
    assign kind = kind_reg;
    assign index_value = idx_reg;
    assign red = red_reg;
    assign green = green_reg;
    assign blue = blue_reg;
    assign column = col_reg;
    assign row = row_reg;
    assign end_of_image = eoi_reg;
    assign error_code = err_reg;

endmodule

[rtl/core/tim_image_stream_decoder_core.sv]
// a result word is written into the command queue, then registered in the output register of the back
// throughput: one byte per cycle while full is low; a 4-bit pixel byte gives two result words at the back
// the grey palette of an untabled 4-bit file gives sixteen result words at the back
// the back emits one word per cycle while pop keeps its output register free, the command queue absorbs the difference
// reset: asynchronous, clears parser phase, queue and output valid; no clearing pass
// ----------------------------------------------------------------------------
// tim image stream decoder core
// byte-wide tim file parser with palette and pixel output queue
// ----------------------------------------------------------------------------
`include "tim_image_stream_decoder_core_defines.svh"

module tim_image_stream_decoder_core
    import tisd_pkg::*;
#(
    parameter int MAX_CLUT_BLOCK_BYTES = DEF_MAX_CLUT_BLOCK_BYTES,
    parameter int CMD_DEPTH = DEF_CMD_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        start_of_file,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  kind,
    output logic [15:0] index_value,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [16:0] column,
    output logic [15:0] row,
    output logic        end_of_image,
    output logic [2:0]  error_code
);

    logic accept;
    logic fifo_push, fifo_full, fifo_pop, fifo_empty;
    cmd_t fifo_wr, fifo_rd;

    assign full = fifo_full;
    assign accept = push && !fifo_full;

    tisd_front #(
        .MAX_CLUT_BLOCK_BYTES(MAX_CLUT_BLOCK_BYTES)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .accept(accept),
        .data_byte(data_byte),
        .start_of_file(start_of_file),
        .cmd_push(fifo_push),
        .cmd(fifo_wr)
    );

    tisd_cmd_fifo #(
        .DEPTH(CMD_DEPTH)
    ) u_fifo (
        .clk(clk),
        .rst_n(rst_n),
        .wr_en(fifo_push),
        .wr_data(fifo_wr),
        .full(fifo_full),
        .rd_en(fifo_pop),
        .rd_data(fifo_rd),
        .empty(fifo_empty)
    );

    tisd_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .head(fifo_rd),
        .q_empty(fifo_empty),
        .q_pop(fifo_pop),
        .empty(empty),
        .pop(pop),
        .kind(kind),
        .index_value(index_value),
        .red(red),
        .green(green),
        .blue(blue),
        .column(column),
        .row(row),
        .end_of_image(end_of_image),
        .error_code(error_code)
    );

    `TISD_ASSERT_IMPLIES(a_push_room, fifo_push, !fifo_full, "command written into a full queue")
    `TISD_ASSERT_IMPLIES(a_pop_data, fifo_pop, !fifo_empty, "command taken from an empty queue")
    `TISD_ASSERT_NEXT(a_pop_shows, fifo_pop, !empty, "finished command left no word")
    `TISD_ASSERT_IMPLIES(a_eoi_pixel, !empty && end_of_image,
        kind == KIND_INDEXED || kind == KIND_COLOUR, "end of image on a non-pixel word")

endmodule
